### hdl/plpb_pkg.sv
// plpb_pkg: shared types and fixed constants of the piecewise linear branch predictor
// no dependencies; imported by every module under hdl
`default_nettype none

package plpb_pkg;

    // result sum format
    localparam int SUM_W  = 13;
    localparam int SUM_HI = 4095;
    localparam int SUM_LO = -4096;

    // input command codes
    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_TRAIN   = 1'b1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int THRESH_W   = 12;
    localparam int WMAX_W     = 7;
    localparam int WMIN_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TRAIN_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MAX      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MIN      = 2'd2;

    // largest table index widths the parameters allow
    localparam int MAX_ROW_W = 12;
    localparam int MAX_IDX_W = 20;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                 clear;    // clearing pass write
        logic [MAX_IDX_W-1:0] clr_idx;  // clearing pass address
        logic                 rd_en;    // read the weight at the current row
        logic                 sum_en;   // advance the partial sum one cell
        logic                 wr_en;    // write back the stepped weight
        logic                 shift;    // shift the history one cell
        logic                 outcome;  // resolved direction of the train transfer
        logic [MAX_ROW_W-1:0] row;      // pc row of the current transfer
    } plpb_ctl_t;

endpackage

`default_nettype wire

### hdl/plpb_wupd.sv
// plpb_wupd: one weight step of +1 or -1 with the configured and storage saturation
// depends on plpb_pkg
`default_nettype none

module plpb_wupd
    import plpb_pkg::*;
#(
    parameter int WEIGHT_BITS = 8
)
(
    input  wire logic signed [WEIGHT_BITS-1:0] w_in,
    input  wire logic                          inc,
    input  wire logic        [WMAX_W-1:0]      weight_max,
    input  wire logic signed [WMIN_W-1:0]      weight_min,
    output      logic signed [WEIGHT_BITS-1:0] w_out
);

    localparam int CW = ((WEIGHT_BITS > WMIN_W) ? WEIGHT_BITS : WMIN_W) + 2;
    localparam logic signed [CW-1:0] STORE_HI = CW'((1 << (WEIGHT_BITS - 1)) - 1);
    localparam logic signed [CW-1:0] STORE_LO = -STORE_HI - CW'(1);

    logic signed [CW-1:0] w_ext;
    logic signed [CW-1:0] lim_hi;
    logic signed [CW-1:0] lim_lo;
    logic signed [CW-1:0] v;

    assign w_ext  = {{(CW-WEIGHT_BITS){w_in[WEIGHT_BITS-1]}}, w_in};
    assign lim_hi = {{(CW-WMAX_W){1'b0}}, weight_max};
    assign lim_lo = {{(CW-WMIN_W){weight_min[WMIN_W-1]}}, weight_min};

    // step, then max limit, min limit, storage range in that order
    always_comb
    begin
        v = inc ? (w_ext + CW'(1)) : (w_ext - CW'(1));
        if (v > lim_hi)
        begin
            v = lim_hi;
        end
        if (v < lim_lo)
        begin
            v = lim_lo;
        end
        if (v > STORE_HI)
        begin
            v = STORE_HI;
        end
        if (v < STORE_LO)
        begin
            v = STORE_LO;
        end
    end

    assign w_out = v[WEIGHT_BITS-1:0];

endmodule

`default_nettype wire

### hdl/plpb_cell.sv
// plpb_cell: one history position: its outcome bit, path address, weight bank and sum stage
// depends on plpb_pkg and plpb_wupd
`default_nettype none

module plpb_cell
    import plpb_pkg::*;
#(
    parameter int PC_INDEX_BITS  = 6,
    parameter int PATH_ADDR_BITS = 4,
    parameter int WEIGHT_BITS    = 8,
    parameter int ACC_W          = 14
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire plpb_ctl_t                     ctl,
    input  wire logic        [WMAX_W-1:0]      weight_max,
    input  wire logic signed [WMIN_W-1:0]      weight_min,
    input  wire logic                          hist_in,
    input  wire logic [PATH_ADDR_BITS-1:0]     addr_in,
    input  wire logic signed [ACC_W-1:0]       psum_in,
    output      logic                          hist_out,
    output      logic [PATH_ADDR_BITS-1:0]     addr_out,
    output      logic signed [ACC_W-1:0]       psum_out
);

    localparam int IDX_W = PC_INDEX_BITS + PATH_ADDR_BITS;
    localparam int DEPTH = 1 << IDX_W;

    logic                          hist_reg;
    logic [PATH_ADDR_BITS-1:0]     addr_reg;
    logic signed [WEIGHT_BITS-1:0] rd_data_reg;
    logic signed [ACC_W-1:0]       psum_reg;
    logic signed [ACC_W-1:0]       psum_next;
    logic signed [ACC_W-1:0]       w_ext;
    logic signed [WEIGHT_BITS-1:0] w_upd;
    logic [IDX_W-1:0]              rw_addr;
    logic signed [WEIGHT_BITS-1:0] mem [DEPTH];

    assign rw_addr = {ctl.row[PC_INDEX_BITS-1:0], addr_reg};

    // weight bank: clearing pass, write back, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            mem[ctl.clr_idx[IDX_W-1:0]] <= '0;
        end
        else if (ctl.wr_en)
        begin
            mem[rw_addr] <= w_upd;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rw_addr];
        end
    end

    // step toward agreement of the history bit with the outcome
    plpb_wupd #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_wupd (
        .w_in       (rd_data_reg),
        .inc        (hist_reg == ctl.outcome),
        .weight_max (weight_max),
        .weight_min (weight_min),
        .w_out      (w_upd)
    );

    // add or subtract this weight from the left neighbor's partial sum
    assign w_ext     = {{(ACC_W-WEIGHT_BITS){rd_data_reg[WEIGHT_BITS-1]}}, rd_data_reg};
    assign psum_next = hist_reg ? (psum_in + w_ext) : (psum_in - w_ext);

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            psum_reg <= psum_next;
        end
    end

    // history shifts one cell toward the oldest position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= 1'b0;
            addr_reg <= '0;
        end
        else if (ctl.shift)
        begin
            hist_reg <= hist_in;
            addr_reg <= addr_in;
        end
    end

    assign hist_out = hist_reg;
    assign addr_out = addr_reg;
    assign psum_out = psum_reg;

endmodule

`default_nettype wire

### hdl/piecewise_linear_branch_predictor.sv
// Piecewise linear branch predictor. After reset a clearing pass writes zero to every
// weight, one entry of each cell's bank per cycle; input stays stalled meanwhile, and
// configuration writes are taken at any time. The predictor is a row of HISTORY_LEN cells,
// one per history position, each with its own weight bank. A predict transfer reads every
// bank at once, then the partial sum passes from cell to cell, one cell per cycle, starting
// from the bias weight, and the saturated sum is loaded into the output register once an
// earlier result there has been taken. A train transfer reads the banks, then shifts the
// history and, when the training decision calls for it, writes the stepped weights back.
// The block works on one item at a time; a result waiting in the output register does not
// keep the next item from being accepted.
// depends on plpb_pkg, plpb_cell, plpb_wupd
`default_nettype none

module piecewise_linear_branch_predictor
    import plpb_pkg::*;
#(
    parameter int PC_INDEX_BITS  = 6,
    parameter int PATH_ADDR_BITS = 4,
    parameter int HISTORY_LEN    = 16,
    parameter int WEIGHT_BITS    = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input channel
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire logic                  cmd,
    input  wire logic [31:0]           pc,
    input  wire logic                  outcome,
    // result channel
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      logic                  taken,
    output      logic signed [SUM_W-1:0] sum,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W      = PC_INDEX_BITS + PATH_ADDR_BITS;
    localparam int BIAS_DEPTH = 1 << PC_INDEX_BITS;
    localparam int ACC_RAW    = WEIGHT_BITS + $clog2(HISTORY_LEN + 1) + 1;
    localparam int ACC_W      = (ACC_RAW > SUM_W + 1) ? ACC_RAW : SUM_W + 1;
    localparam int CNT_W      = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(SUM_HI);
    localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(SUM_LO);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_SUM   = 6'b001000,
        S_DONE  = 6'b010000,
        S_TRAIN = 6'b100000
    } state_t;

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0]       last_sum_reg, last_sum_next;
    logic [THRESH_W-1:0]           thresh_reg;
    logic [WMAX_W-1:0]             wmax_reg;
    logic signed [WMIN_W-1:0]      wmin_reg;
    logic                          cmd_reg;
    logic                          outcome_reg;
    logic [PC_INDEX_BITS-1:0]      row_reg;
    logic [PATH_ADDR_BITS-1:0]     paddr_reg;
    logic                          taken_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [WEIGHT_BITS-1:0] bias_rd_reg;
    logic signed [WEIGHT_BITS-1:0] bias_upd;
    logic signed [WEIGHT_BITS-1:0] bias_mem [BIAS_DEPTH];
    logic                          in_xfer;
    logic                          out_load;
    logic                          do_train;
    logic [SUM_W-1:0]              mag;
    logic signed [ACC_W-1:0]       sat_acc;
    plpb_ctl_t                     ctl;

    logic                          hist_chain [HISTORY_LEN];
    logic [PATH_ADDR_BITS-1:0]     addr_chain [HISTORY_LEN];
    logic signed [ACC_W-1:0]       psum_chain [HISTORY_LEN+1];

    assign in_xfer   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_W'(45);
            wmax_reg   <= WMAX_W'(127);
            wmin_reg   <= WMIN_W'(-128);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TRAIN_THRESHOLD: thresh_reg <= cfg_data[THRESH_W-1:0];
                CFG_WEIGHT_MAX:      wmax_reg   <= cfg_data[WMAX_W-1:0];
                CFG_WEIGHT_MIN:      wmin_reg   <= cfg_data[WMIN_W-1:0];
                default:             ;
            endcase
        end
    end

    // training decision from the most recent prediction
    assign mag      = last_sum_reg[SUM_W-1] ? SUM_W'(-last_sum_reg) : last_sum_reg;
    assign do_train = (last_sum_reg[SUM_W-1] == outcome_reg)
                   || (mag <= {1'b0, thresh_reg});

    // saturate the chain result to the sum range
    always_comb
    begin
        sat_acc = psum_chain[HISTORY_LEN];
        if (sat_acc > ACC_HI)
        begin
            sat_acc = ACC_HI;
        end
        if (sat_acc < ACC_LO)
        begin
            sat_acc = ACC_LO;
        end
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        last_sum_next  = last_sum_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == {IDX_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cnt_next   = '0;
                state_next = (cmd_reg == CMD_TRAIN) ? S_TRAIN : S_SUM;
            end
            S_SUM:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(HISTORY_LEN - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    last_sum_next  = sat_acc[SUM_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            S_TRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_sum_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            last_sum_reg  <= last_sum_next;
        end
    end

    // input transfer and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg     <= cmd;
            outcome_reg <= outcome;
            row_reg     <= pc[PC_INDEX_BITS-1:0];
            paddr_reg   <= pc[PATH_ADDR_BITS-1:0];
        end
        if (out_load)
        begin
            taken_reg <= !sat_acc[ACC_W-1];
            sum_reg   <= sat_acc[SUM_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign taken     = taken_reg;
    assign sum       = sum_reg;

    // control broadcast to the cells
    always_comb
    begin
        ctl         = '0;
        ctl.clear   = (state_reg == S_CLEAR);
        ctl.clr_idx = MAX_IDX_W'(clr_idx_reg);
        ctl.rd_en   = (state_reg == S_READ);
        ctl.sum_en  = (state_reg == S_SUM);
        ctl.wr_en   = (state_reg == S_TRAIN) && do_train;
        ctl.shift   = (state_reg == S_TRAIN);
        ctl.outcome = outcome_reg;
        ctl.row     = MAX_ROW_W'(row_reg);
    end

    // bias table
    plpb_wupd #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_bias_upd (
        .w_in       (bias_rd_reg),
        .inc        (outcome_reg),
        .weight_max (wmax_reg),
        .weight_min (wmin_reg),
        .w_out      (bias_upd)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            bias_mem[clr_idx_reg[PC_INDEX_BITS-1:0]] <= '0;
        end
        else if (ctl.wr_en)
        begin
            bias_mem[row_reg] <= bias_upd;
        end
        if (ctl.rd_en)
        begin
            bias_rd_reg <= bias_mem[row_reg];
        end
    end

    // chain head: bias starts the sum, the new outcome and pc bits enter the history
    assign psum_chain[0] = {{(ACC_W-WEIGHT_BITS){bias_rd_reg[WEIGHT_BITS-1]}}, bias_rd_reg};
    assign hist_chain[0] = outcome_reg;
    assign addr_chain[0] = paddr_reg;

    for (genvar j = 0; j < HISTORY_LEN; j++)
    begin : g_cell
        if (j < HISTORY_LEN - 1)
        begin : g_mid
            plpb_cell #(
                .PC_INDEX_BITS  (PC_INDEX_BITS),
                .PATH_ADDR_BITS (PATH_ADDR_BITS),
                .WEIGHT_BITS    (WEIGHT_BITS),
                .ACC_W          (ACC_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .weight_max (wmax_reg),
                .weight_min (wmin_reg),
                .hist_in    (hist_chain[j]),
                .addr_in    (addr_chain[j]),
                .psum_in    (psum_chain[j]),
                .hist_out   (hist_chain[j+1]),
                .addr_out   (addr_chain[j+1]),
                .psum_out   (psum_chain[j+1])
            );
        end
        else
        begin : g_last
            plpb_cell #(
                .PC_INDEX_BITS  (PC_INDEX_BITS),
                .PATH_ADDR_BITS (PATH_ADDR_BITS),
                .WEIGHT_BITS    (WEIGHT_BITS),
                .ACC_W          (ACC_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .weight_max (wmax_reg),
                .weight_min (wmin_reg),
                .hist_in    (hist_chain[j]),
                .addr_in    (addr_chain[j]),
                .psum_in    (psum_chain[j]),
                .hist_out   (),
                .addr_out   (),
                .psum_out   (psum_chain[j+1])
            );
        end
    end

    // a result appears only out of the final sum state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the final sum state");

    // a train transfer causes no result
    a_train_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (cmd == CMD_TRAIN)) |=> !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("train transfer produced a result");

    // no input transfer during the clearing pass
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("input accepted during clearing pass");

    // prediction agrees with the sign of the sum
    a_taken_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (taken == !sum[SUM_W-1]))
        else $error("taken disagrees with sum sign");

endmodule

`default_nettype wire
